// ===== rtl/sha256_stream_hasher_assert.svh =====
// assertion macros shared by the checker
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// implication checked on every clock outside reset
`define SHA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define SHA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/sha_pkg.sv =====
`timescale 1ns / 1ps
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] digest_byte;
        logic       digest_last;
    } out_item_t;

    // datapath commands
    typedef struct packed {
        logic       load_byte;   // write byte at fill pointer
        logic       pad_byte;    // write pad byte at pad pointer
        logic [7:0] pad_value;
        logic [5:0] pad_addr;
        logic       start;       // begin compression
        logic       init_words;  // load working vars from chain
        logic       round;       // one round
        logic       fold;        // add working vars into chain
        logic       reset_chain; // back to initial values
        logic       load_digest; // latch digest for emission
        logic       shift_digest;// next digest byte
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] round_idx;
    } dp_stat_t;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RC [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam int unsigned DIGEST_LEN = 32;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/sha_datapath.sv =====
`timescale 1ns / 1ps
module sha_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           data_byte,
    input  logic [5:0]           fill_addr,
    input  logic                 order,
    input  sha_pkg::dp_cmd_t     cmd,
    output sha_pkg::dp_stat_t    stat,
    output logic [7:0]           digest_byte
);

    logic [7:0]   block_mem [64];
    logic [31:0]  chain_reg [8];
    logic [31:0]  var_reg [8];
    logic [511:0] sched_reg;
    logic [5:0]   round_reg;
    logic [5:0]   load_idx_reg;
    logic         loading_reg;
    logic         shift_in_reg;
    logic [255:0] dig_reg;

    // block buffer: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.load_byte) begin
            block_mem[fill_addr] <= data_byte;
        end else if (cmd.pad_byte) begin
            block_mem[cmd.pad_addr] <= cmd.pad_value;
        end
    end

    // registered read of the byte at the loader address
    logic [7:0] rd_byte_reg;
    always_ff @(posedge aclk) begin
        rd_byte_reg <= block_mem[load_idx_reg];
    end

    // message schedule step
    logic [31:0] w0, w1, w9, w14, s0, s1, w_new;
    always_comb begin
        w0    = sched_reg[511:480];
        w1    = sched_reg[479:448];
        w9    = sched_reg[223:192];
        w14   = sched_reg[63:32];
        s0    = sha_pkg::ror32(w1, 7) ^ sha_pkg::ror32(w1, 18) ^ (w1 >> 3);
        s1    = sha_pkg::ror32(w14, 17) ^ sha_pkg::ror32(w14, 19) ^ (w14 >> 10);
        w_new = s1 + w9 + s0 + w0;
    end

    // round function
    logic [31:0] t1, t2, e, a;
    always_comb begin
        e  = var_reg[4];
        a  = var_reg[0];
        t1 = var_reg[7] + (sha_pkg::ror32(e, 6) ^ sha_pkg::ror32(e, 11) ^ sha_pkg::ror32(e, 25))
             + ((e & var_reg[5]) ^ (~e & var_reg[6])) + sha_pkg::RC[round_reg] + w0;
        t2 = (sha_pkg::ror32(a, 2) ^ sha_pkg::ror32(a, 13) ^ sha_pkg::ror32(a, 22))
             + ((a & var_reg[1]) ^ (a & var_reg[2]) ^ (var_reg[1] & var_reg[2]));
    end

    // byte loader: 64 reads, one per cycle, each shifted in on the cycle after its read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loading_reg  <= 1'b0;
            load_idx_reg <= '0;
            shift_in_reg <= 1'b0;
        end else begin
            shift_in_reg <= loading_reg;
            if (cmd.start) begin
                loading_reg  <= 1'b1;
                load_idx_reg <= '0;
            end else if (loading_reg) begin
                load_idx_reg <= load_idx_reg + 6'd1;
                if (load_idx_reg == 6'd63) begin
                    loading_reg <= 1'b0;
                end
            end
        end
    end

    // schedule register and working variables
    always_ff @(posedge aclk) begin
        if (shift_in_reg) begin
            sched_reg <= {sched_reg[503:0], rd_byte_reg};
        end else if (cmd.round) begin
            sched_reg <= {sched_reg[479:0], w_new};
        end
        if (!aresetn) begin
            round_reg <= '0;
        end else if (cmd.init_words) begin
            round_reg <= '0;
        end else if (cmd.round) begin
            round_reg <= round_reg + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.reset_chain) begin
            for (int i = 0; i < 8; i++) chain_reg[i] <= sha_pkg::IV[i];
        end else if (cmd.fold) begin
            for (int i = 0; i < 8; i++) chain_reg[i] <= chain_reg[i] + var_reg[i];
        end
        if (cmd.init_words) begin
            for (int i = 0; i < 8; i++) var_reg[i] <= chain_reg[i];
        end else if (cmd.round) begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

    // digest shift register, byte-reversed when configured
    logic [255:0] dig_std, dig_rev;
    always_comb begin
        dig_std = {chain_reg[0], chain_reg[1], chain_reg[2], chain_reg[3],
                   chain_reg[4], chain_reg[5], chain_reg[6], chain_reg[7]};
        for (int i = 0; i < 32; i++) dig_rev[i*8 +: 8] = dig_std[(31-i)*8 +: 8];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_digest) begin
            dig_reg <= order ? dig_rev : dig_std;
        end else if (cmd.shift_digest) begin
            dig_reg <= {dig_reg[247:0], 8'h00};
        end
    end

    assign digest_byte = dig_reg[255:248];
    assign stat.round_idx = round_reg;

endmodule

// ===== rtl/sha_control.sv =====
`timescale 1ns / 1ps
module sha_control (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sha_pkg::in_item_t    s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_last,
    output logic [5:0]           fill_addr,
    output sha_pkg::dp_cmd_t     cmd,
    input  sha_pkg::dp_stat_t    stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FOLD  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;
    localparam logic [2:0] ST_DIG   = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [6:0]  fill_reg, fill_next;     // bit 6 set once the pad mark is written
    logic [63:0] bits_reg, bits_next;
    logic [63:0] total_reg, total_next;
    logic        final_reg, final_next;   // compression is part of finish
    logic        second_reg, second_next; // another pad block still to run
    logic [6:0]  cnt_reg, cnt_next;
    logic [5:0]  pad_ptr_reg, pad_ptr_next;

    logic acc;
    assign acc       = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign fill_addr = fill_reg[5:0];
    assign m_valid   = (state_reg == ST_EMIT);
    assign m_last    = (cnt_reg == 7'd31);

    // pad byte for the current pointer
    function automatic logic [7:0] len_byte(input logic [63:0] t, input logic [5:0] p);
        len_byte = t[(63 - p) * 8 +: 8];
    endfunction

    // sequencer
    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        bits_next   = bits_reg;
        total_next  = total_reg;
        final_next  = final_reg;
        second_next = second_reg;
        cnt_next    = cnt_reg;
        pad_ptr_next = pad_ptr_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    if (s_item.byte_present) begin
                        cmd.load_byte = 1'b1;
                        fill_next = fill_reg + 7'd1;
                    end
                    if (s_item.byte_present && fill_reg == 7'd63) begin
                        // full block; a message ending here pads a fresh block after it
                        fill_next   = '0;
                        bits_next   = bits_reg + 64'd512;
                        total_next  = bits_reg + 64'd512;
                        final_next  = s_item.end_of_message;
                        second_next = s_item.end_of_message;
                        cmd.start   = 1'b1;
                        cnt_next    = '0;
                        state_next  = ST_LOAD;
                    end else if (s_item.end_of_message) begin
                        pad_ptr_next = fill_next[5:0];
                        total_next = bits_reg + {55'd0, fill_next[5:0], 3'd0};
                        state_next = ST_PAD;
                        second_next = (fill_next[5:0] >= 6'd56);
                    end
                end
            end
            ST_PAD: begin
                // write mark, zeros and length one byte a cycle
                cmd.pad_byte = 1'b1;
                cmd.pad_addr = pad_ptr_reg;
                if (pad_ptr_reg == fill_reg[5:0] && !fill_reg[6]) begin
                    cmd.pad_value = sha_pkg::PAD_MARK;
                end else if (pad_ptr_reg >= 6'd56 && !second_reg) begin
                    cmd.pad_value = len_byte(total_reg, pad_ptr_reg);
                end else begin
                    cmd.pad_value = 8'h00;
                end
                pad_ptr_next = pad_ptr_reg + 6'd1;
                if (pad_ptr_reg == 6'd63) begin
                    fill_next  = 7'd64;
                    cmd.start  = 1'b1;
                    cnt_next   = '0;
                    final_next = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // block bytes stream into the schedule
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd66) begin
                    cmd.init_words = 1'b1;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                if (stat.round_idx == 6'd63) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.fold = 1'b1;
                state_next = ST_IDLE;
                if (final_reg) begin
                    if (second_reg) begin
                        second_next  = 1'b0;
                        pad_ptr_next = '0;
                        state_next   = ST_PAD;
                    end else begin
                        state_next = ST_DIG;
                    end
                end
            end
            ST_DIG: begin
                cmd.load_digest = 1'b1;
                cmd.reset_chain = 1'b1;
                cnt_next   = '0;
                fill_next  = '0;
                bits_next  = '0;
                final_next = 1'b0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    cmd.shift_digest = 1'b1;
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd31) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            bits_reg    <= '0;
            total_reg   <= '0;
            final_reg   <= 1'b0;
            second_reg  <= 1'b0;
            cnt_reg     <= '0;
            pad_ptr_reg <= '0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            bits_reg    <= bits_next;
            total_reg   <= total_next;
            final_reg   <= final_next;
            second_reg  <= second_next;
            cnt_reg     <= cnt_next;
            pad_ptr_reg <= pad_ptr_next;
        end
    end

endmodule

// ===== rtl/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
// Byte-stream SHA-256 hasher. One item is taken per cycle while a block fills;
// a 64th byte starts a compression (stream the block buffer through its single
// registered read port into the schedule and load the working variables, then
// 64 rounds on one shared round unit, then one fold). End of message writes
// the pad bytes one a cycle from the fill point to the block end (all 64 for an
// extra block), runs one or two compressions (an extra pad block when the fill is
// 56 or more, or when the end comes with a 64th byte), latches the digest,
// then the 32 digest bytes leave one per cycle under m_ready. The order
// bit on the cfg port picks standard or fully byte-reversed digest order; write
// it only while the hasher is idle.
// No items are taken during compression, padding or emission.
module sha256_stream_hasher (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sha_pkg::in_item_t     s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sha_pkg::out_item_t    m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);

    sha_pkg::dp_cmd_t  cmd;
    sha_pkg::dp_stat_t stat;
    logic [5:0] fill_addr;
    logic       last;
    logic [7:0] dig_byte;
    logic       order_reg;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= 1'b0;
        end else if (cfg_valid) begin
            order_reg <= cfg_data;
        end
    end

    sha_control u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_item(s_data), .m_valid, .m_ready,
        .m_last(last), .fill_addr, .cmd, .stat
    );

    sha_datapath u_dp (
        .aclk, .aresetn, .data_byte(s_data.data_byte), .fill_addr, .order(order_reg),
        .cmd, .stat, .digest_byte(dig_byte)
    );

    assign m_data = {dig_byte, last};

endmodule

// ===== rtl/sha_checker.sv =====
`timescale 1ns / 1ps
`include "sha256_stream_hasher_assert.svh"
module sha_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_last
);
    // no new request taken while digest bytes are pending
    `SHA_ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_valid, !s_ready)
    // result held under backpressure
    `SHA_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    // after the last byte the result side goes quiet
    `SHA_ASSERT_NEXT(a_last_done, aclk, aresetn, m_valid && m_ready && m_last, !m_valid)
endmodule

bind sha256_stream_hasher sha_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_last(m_data.digest_last)
);
